// ===== sv/rclp_pkg.sv =====
// Package for the color line parser: codes, character constants and helper functions.
package rclp_pkg;

  // Number of color targets that carry a filled flag.
  localparam int unsigned SlotCount = 2;

  localparam int unsigned PhaseW = 4;
  localparam int unsigned AccW   = 9;

  // Parser phase codes.
  localparam logic [PhaseW-1:0] PhId     = 4'd0;
  localparam logic [PhaseW-1:0] PhSep    = 4'd1;
  localparam logic [PhaseW-1:0] PhBlank  = 4'd2;
  localparam logic [PhaseW-1:0] PhRDig   = 4'd3;
  localparam logic [PhaseW-1:0] PhGFirst = 4'd4;
  localparam logic [PhaseW-1:0] PhGDig   = 4'd5;
  localparam logic [PhaseW-1:0] PhBFirst = 4'd6;
  localparam logic [PhaseW-1:0] PhBDig   = 4'd7;
  localparam logic [PhaseW-1:0] PhTrail  = 4'd8;

  // Result status codes.
  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFilled  = 2'd1;
  localparam logic [1:0] StatusInvalid = 2'd2;

  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharTab   = 8'd9;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [AccW-1:0] AccSat  = 9'd256;
  localparam logic [AccW-1:0] CompMax = 9'd255;

  // Summary of a finished line, handed from the parser to the result stage.
  typedef struct packed {
    logic        well_formed;
    logic [23:0] rgb;
  } line_sum_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CharSpace) || (c == CharTab);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

  // Decimal accumulate, saturating at AccSat.
  function automatic logic [AccW-1:0] acc_add(input logic [AccW-1:0] acc,
                                             input logic [7:0] c);
    logic [11:0] prod;
    logic [11:0] sum;
    begin
      prod = ({3'd0, acc} << 3) + ({3'd0, acc} << 1);
      sum  = prod + {4'd0, c - CharZero};
      return (sum > {3'd0, AccSat}) ? AccSat : sum[AccW-1:0];
    end
  endfunction

endpackage

// ===== sv/rclp_if.sv =====
// Handshake interfaces for the byte requests and the result requests.
interface rclp_in_if;
  logic       valid;
  logic       ready;
  logic       slot;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, output slot, output char_in, output line_end, input ready);
  modport sink   (input valid, input slot, input char_in, input line_end, output ready);
endinterface

interface rclp_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] rgb_packed;
  logic [1:0]  status;
  logic        slot_out;

  modport source (output valid, output rgb_packed, output status, output slot_out,
                  input ready);
  modport sink   (input valid, input rgb_packed, input status, input slot_out,
                  output ready);
endinterface

// ===== sv/rclp_line_fsm.sv =====
// Byte-level line parser: phase state machine, component accumulator and line check.
module rclp_line_fsm
  import rclp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] char_i,
  input  logic       line_end_i,
  output line_sum_t  line_o
);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [AccW-1:0]   red_q, red_d;
  logic [AccW-1:0]   green_q, green_d;
  logic              bad_q, bad_d;

  logic dig;
  logic blank;

  assign dig   = is_digit(char_i);
  assign blank = is_blank(char_i);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    red_d   = red_q;
    green_d = green_q;
    bad_d   = bad_q;
    if (take_i) begin
      if (line_end_i) begin
        phase_d = PhId;
        acc_d   = '0;
        red_d   = '0;
        green_d = '0;
        bad_d   = 1'b0;
      end else if (!bad_q) begin
        case (phase_q)
          PhId: begin
            phase_d = PhSep;
          end
          PhSep: begin
            if (blank) phase_d = PhBlank;
            else       bad_d   = 1'b1;
          end
          PhBlank: begin
            if (dig) begin
              acc_d   = acc_add('0, char_i);
              phase_d = PhRDig;
            end else if (!blank) begin
              bad_d = 1'b1;
            end
          end
          PhRDig, PhGDig: begin
            if (dig) begin
              acc_d = acc_add(acc_q, char_i);
            end else if (char_i == CharComma) begin
              if (phase_q == PhRDig) begin
                red_d   = acc_q;
                phase_d = PhGFirst;
              end else begin
                green_d = acc_q;
                phase_d = PhBFirst;
              end
              acc_d = '0;
            end else begin
              bad_d = 1'b1;
            end
          end
          PhGFirst, PhBFirst: begin
            if (dig) begin
              acc_d   = acc_add('0, char_i);
              phase_d = (phase_q == PhGFirst) ? PhGDig : PhBDig;
            end else begin
              bad_d = 1'b1;
            end
          end
          PhBDig: begin
            if (dig)        acc_d   = acc_add(acc_q, char_i);
            else if (blank) phase_d = PhTrail;
            else            bad_d   = 1'b1;
          end
          PhTrail: begin
            if (!blank) bad_d = 1'b1;
          end
          default: begin
            bad_d = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhId;
      acc_q   <= '0;
      red_q   <= '0;
      green_q <= '0;
      bad_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      red_q   <= red_d;
      green_q <= green_d;
      bad_q   <= bad_d;
    end
  end

  // Check of the line as it stands, used when the terminator arrives.
  assign line_o.well_formed = !bad_q && ((phase_q == PhBDig) || (phase_q == PhTrail)) &&
                              (red_q <= CompMax) && (green_q <= CompMax) &&
                              (acc_q <= CompMax);
  assign line_o.rgb = {red_q[7:0], green_q[7:0], acc_q[7:0]};

endmodule

// ===== sv/rclp_slot_flags.sv =====
// Per-slot filled flags that reject a second successful line for the same slot.
module rclp_slot_flags
  import rclp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic slot_i,
  input  logic set_i,
  output logic filled_o
);

  logic [SlotCount-1:0] filled_q, filled_d;
  logic [SlotCount-1:0] sel;

  // A slot value at or above SlotCount selects no flag.
  always_comb begin
    for (int unsigned i = 0; i < SlotCount; i++) begin
      sel[i] = ({31'd0, slot_i} == i);
    end
  end

  assign filled_o = |(filled_q & sel);
  assign filled_d = set_i ? (filled_q | sel) : filled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else begin
      filled_q <= filled_d;
    end
  end

endmodule

// ===== sv/rgb_color_line_parser_unit.sv =====
// Top level of the color line parser: byte requests in, one result request per line out.
//
//   channel | modport      | moves
//   --------+--------------+---------------------------------------------
//   in_i    | rclp_in_if   | one line byte or a line terminator
//   out_o   | rclp_out_if  | packed color, status and slot for each line
//
// A new byte request is accepted in every cycle unless a result waits unaccepted.
// A terminator's result appears in the output register in the cycle after it is taken.
// Reset (rst_ni low, asynchronous) clears the parser phase, the accumulated
// components and all slot filled flags.
// While a result waits unaccepted, input is still taken when the sink takes
// the result in the same cycle; otherwise the input stalls for that cycle.
module rgb_color_line_parser_unit
  import rclp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rclp_in_if.sink    in_i,
  rclp_out_if.source out_o
);

  logic      take;
  logic      take_end;
  logic      filled;
  logic      set_flag;
  line_sum_t line_sum;
  logic [1:0] status;

  logic        out_valid_q, out_valid_d;
  logic [23:0] rgb_q;
  logic [1:0]  status_q;
  logic        slot_q;

  // The input may move whenever the output register is empty or being drained.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign take_end   = take && in_i.line_end;

  rclp_line_fsm u_fsm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .take_i     (take),
    .char_i     (in_i.char_in),
    .line_end_i (in_i.line_end),
    .line_o     (line_sum)
  );

  // The filled check wins over a malformed line.
  always_comb begin
    if (filled)                    status = StatusFilled;
    else if (!line_sum.well_formed) status = StatusInvalid;
    else                           status = StatusOk;
  end

  assign set_flag = take_end && (status == StatusOk);

  rclp_slot_flags u_flags (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .slot_i   (in_i.slot),
    .set_i    (set_flag),
    .filled_o (filled)
  );

  // Result register: loads on a terminator, empties when the sink accepts.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_end)          out_valid_d = 1'b1;
    else if (out_o.ready)  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_end) begin
      rgb_q    <= (status == StatusOk) ? line_sum.rgb : 24'd0;
      status_q <= status;
      slot_q   <= in_i.slot;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.rgb_packed = rgb_q;
  assign out_o.status     = status_q;
  assign out_o.slot_out   = slot_q;

endmodule

// ===== tb/tb_rgb_color_line_parser_unit.sv =====
// Testbench for the color line parser: directed and random lines checked against a predictor.
module tb_rgb_color_line_parser_unit
  import rclp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems = 1900;
  localparam int unsigned CalmItems   = 250;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned DrainCycles = 8;

  // Tracks the parser state byte by byte and holds the result that each
  // terminator is due to produce, oldest first.
  class color_line_scoreboard;
    typedef struct packed {
      logic [23:0] rgb;
      logic [1:0]  status;
      logic        slot;
    } line_result_t;

    line_result_t      expected_q[$];
    logic [PhaseW-1:0] phase;
    int unsigned       acc;
    int unsigned       red;
    int unsigned       green;
    bit                line_bad;
    bit                slot_filled[SlotCount];
    int unsigned       errors;

    function new();
      foreach (slot_filled[i]) slot_filled[i] = 1'b0;
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase    = PhId;
      acc      = 0;
      red      = 0;
      green    = 0;
      line_bad = 1'b0;
    endfunction

    function bit blank_char(logic [7:0] c);
      return (c == CharSpace) || (c == CharTab);
    endfunction

    function bit digit_char(logic [7:0] c);
      return (c >= CharZero) && (c <= CharNine);
    endfunction

    // Appends one decimal digit, pinning the component at 256 so that any
    // longer number still reads as out of range.
    function int unsigned shift_in_digit(int unsigned a, logic [7:0] c);
      int unsigned v;
      v = a * 10 + (int'(c) - int'(CharZero));
      return (v > int'(AccSat)) ? int'(AccSat) : v;
    endfunction

    function void parse_byte(logic [7:0] c);
      bit dig;
      dig = digit_char(c);
      case (phase)
        PhId: phase = PhSep;
        PhSep: begin
          if (blank_char(c)) phase = PhBlank;
          else line_bad = 1'b1;
        end
        PhBlank: begin
          if (dig) begin
            acc   = shift_in_digit(0, c);
            phase = PhRDig;
          end else if (!blank_char(c)) begin
            line_bad = 1'b1;
          end
        end
        PhRDig, PhGDig: begin
          if (dig) begin
            acc = shift_in_digit(acc, c);
          end else if (c == CharComma) begin
            if (phase == PhRDig) begin
              red   = acc;
              phase = PhGFirst;
            end else begin
              green = acc;
              phase = PhBFirst;
            end
            acc = 0;
          end else begin
            line_bad = 1'b1;
          end
        end
        PhGFirst, PhBFirst: begin
          if (dig) begin
            acc   = shift_in_digit(0, c);
            phase = (phase == PhGFirst) ? PhGDig : PhBDig;
          end else begin
            line_bad = 1'b1;
          end
        end
        PhBDig: begin
          if (dig) acc = shift_in_digit(acc, c);
          else if (blank_char(c)) phase = PhTrail;
          else line_bad = 1'b1;
        end
        PhTrail: begin
          if (!blank_char(c)) line_bad = 1'b1;
        end
        default: line_bad = 1'b1;
      endcase
    endfunction

    function void note_input(logic slot, logic [7:0] c, logic line_end);
      line_result_t r;
      if (!line_end) begin
        if (!line_bad) parse_byte(c);
        return;
      end
      r.slot = slot;
      r.rgb  = '0;
      // A slot that already holds a color refuses the line before any
      // check of its contents.
      if ((slot < SlotCount) && slot_filled[slot]) begin
        r.status = StatusFilled;
      end else if (line_bad || ((phase != PhBDig) && (phase != PhTrail)) ||
                   (red > int'(CompMax)) || (green > int'(CompMax)) ||
                   (acc > int'(CompMax))) begin
        r.status = StatusInvalid;
      end else begin
        r.status = StatusOk;
        r.rgb    = {red[7:0], green[7:0], acc[7:0]};
        if (slot < SlotCount) slot_filled[slot] = 1'b1;
      end
      expected_q.push_back(r);
      clear_line();
    endfunction

    function void check_result(logic [23:0] rgb, logic [1:0] status, logic slot);
      line_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no line pending: rgb_packed %h status %0d slot_out %0d",
               rgb, status, slot);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (rgb !== e.rgb) begin
        $error("rgb_packed: expected %h, actual %h", e.rgb, rgb);
        errors++;
      end
      if (status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, status);
        errors++;
      end
      if (slot !== e.slot) begin
        $error("slot_out: expected %0d, actual %0d", e.slot, slot);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Idling switch shared by both sides; cleared for the closing stretch.
  bit idle_en = 1'b1;

  int unsigned items_sent  = 0;
  int unsigned cycle_count = 0;
  logic [7:0]  line_buf[$];

  color_line_scoreboard sb = new();

  rclp_in_if  in_if ();
  rclp_out_if out_if ();

  rgb_color_line_parser_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #6 clk = ~clk;

  // Both channels are sampled at the clock edge, before any of the values
  // driven at that edge take effect.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_input(in_if.slot, in_if.char_in, in_if.line_end);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_result(out_if.rgb_packed, out_if.status, out_if.slot_out);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: ready is dropped at random while idling
  // is enabled, and stays high otherwise.
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_en && ($urandom_range(0, 5) == 0)) begin
        stall_left = $urandom_range(1, 9) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offers one byte request and waits for it to be taken. Called at a clock
  // edge; returns at the edge that accepted it, possibly after an idle gap.
  // Valid is only lowered for a gap, so it is never lowered and raised in
  // the same step.
  task automatic send_byte(input logic slot, input logic [7:0] c, input logic line_end);
    in_if.valid    <= 1'b1;
    in_if.slot     <= slot;
    in_if.char_in  <= c;
    in_if.line_end <= line_end;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    if (idle_en && ($urandom_range(0, 7) == 0)) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // Sends the bytes held in line_buf and then the terminator. The body may
  // carry a different slot than the terminator; only the latter counts.
  task automatic send_line(input logic body_slot, input logic end_slot);
    foreach (line_buf[i]) send_byte(body_slot, line_buf[i], 1'b0);
    send_byte(end_slot, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic send_text(input string s, input logic body_slot, input logic end_slot);
    line_buf.delete();
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line(body_slot, end_slot);
  endtask

  // Bytes biased toward the characters that the parser reacts to.
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'(int'(CharZero) + $urandom_range(0, 9));
      2:       return CharComma;
      default: return ($urandom_range(0, 1) != 0) ? CharTab : CharSpace;
    endcase
  endfunction

  function automatic void push_value(int unsigned v, int unsigned lead);
    logic [7:0] digs[$];
    repeat (lead) line_buf.push_back(CharZero);
    do begin
      digs.push_front(8'(int'(CharZero) + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) line_buf.push_back(digs[i]);
  endfunction

  // Most lines follow the expected layout with random content. Nearly all
  // of those carry one component above 255: a valid line fills its slot for
  // good, after which every further line for that slot is refused, so valid
  // lines are kept rare. Some of them are then damaged; the rest is plain noise.
  function automatic void build_line();
    int unsigned comp[3];
    int unsigned kind;
    int unsigned pos;
    line_buf.delete();
    kind = $urandom_range(0, 15);
    if (kind >= 14) begin
      repeat ($urandom_range(0, 12)) line_buf.push_back(noise_byte());
      return;
    end
    line_buf.push_back(8'($urandom_range(0, 255)));
    line_buf.push_back(($urandom_range(0, 1) != 0) ? CharTab : CharSpace);
    repeat ($urandom_range(0, 2)) begin
      line_buf.push_back(($urandom_range(0, 1) != 0) ? CharTab : CharSpace);
    end
    foreach (comp[k]) begin
      case ($urandom_range(0, 5))
        0:       comp[k] = 0;
        1:       comp[k] = 255;
        default: comp[k] = $urandom_range(0, 255);
      endcase
    end
    if ($urandom_range(0, 15) != 0) begin
      case ($urandom_range(0, 2))
        0:       comp[$urandom_range(0, 2)] = 256;
        1:       comp[$urandom_range(0, 2)] = $urandom_range(257, 999);
        default: comp[$urandom_range(0, 2)] = $urandom_range(1000, 99999);
      endcase
    end
    foreach (comp[k]) begin
      push_value(comp[k], ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      if (k < 2) line_buf.push_back(CharComma);
    end
    repeat ($urandom_range(0, 2)) begin
      line_buf.push_back(($urandom_range(0, 1) != 0) ? CharTab : CharSpace);
    end
    if (kind >= 10) begin
      pos = $urandom_range(0, line_buf.size() - 1);
      case ($urandom_range(0, 2))
        0: line_buf.insert(pos, noise_byte());
        1: while (line_buf.size() > pos) void'(line_buf.pop_back());
        default: line_buf[pos] = noise_byte();
      endcase
    end
  endfunction

  initial begin : stimulus
    logic end_slot;
    in_if.valid    <= 1'b0;
    in_if.slot     <= 1'b0;
    in_if.char_in  <= 8'd0;
    in_if.line_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines; none of them is valid, so both slots stay free.
    send_byte(1'b0, 8'hff, 1'b1);            // empty line
    send_text("C 7", 1'b1, 1'b0);            // ends before green, slot switched at the end
    send_text("C x9", 1'b0, 1'b0);           // bytes after an error are ignored
    send_text("F\t256,0,0", 1'b1, 1'b1);     // red one past the top

    while (items_sent < RandomItems) begin
      idle_en  <= (items_sent + CalmItems < RandomItems) ? ($urandom_range(0, 3) != 0) : 1'b0;
      end_slot = 1'($urandom_range(0, 1));
      build_line();
      send_line(($urandom_range(0, 7) == 0) ? ~end_slot : end_slot, end_slot);
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
